>>> rtl/core/gnh_pkg.sv
// ----------------------------------------------------------------------------
// gnh_pkg
// Shared types and constants of the greedy next-hop table.
// ----------------------------------------------------------------------------
package gnh_pkg;

	localparam int unsigned NEIGHBORS = 32;
	localparam int unsigned IDX_W = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
	localparam int unsigned CNT_W = $clog2(NEIGHBORS + 1);

	localparam int unsigned COORD_W = 16;
	localparam int unsigned ID_W = 16;
	localparam int unsigned SQ_W = 2 * COORD_W;
	localparam int unsigned DIST_W = SQ_W + 1;
	localparam int unsigned NCOUNT_W = 6;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OWN_ID = 2'd0,
		REG_OWN_X  = 2'd1,
		REG_OWN_Y  = 2'd2
	} gnh_reg_t;

	typedef enum logic {
		MODE_UPDATE = 1'b0,
		MODE_QUERY  = 1'b1
	} gnh_mode_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} gnh_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} gnh_state_t;

endpackage

>>> rtl/core/gnh_in_if.sv
// ----------------------------------------------------------------------------
// gnh_in_if
// Item channel: neighbor announcements and next-hop queries.
// ----------------------------------------------------------------------------
interface gnh_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] node_id;
	logic [15:0] pos_x;
	logic [15:0] pos_y;

	modport source (output valid, mode, node_id, pos_x, pos_y, input ready);
	modport sink (input valid, mode, node_id, pos_x, pos_y, output ready);
endinterface

>>> rtl/core/gnh_out_if.sv
// ----------------------------------------------------------------------------
// gnh_out_if
// Result channel: chosen next hop and table status.
// ----------------------------------------------------------------------------
interface gnh_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] next_id;
	logic [15:0] next_x;
	logic [15:0] next_y;
	logic        stuck;
	logic        added;
	logic        table_full;
	logic [5:0]  neighbor_count;

	modport source (output valid, next_id, next_x, next_y, stuck, added, table_full,
		neighbor_count, input ready);
	modport sink (input valid, next_id, next_x, next_y, stuck, added, table_full,
		neighbor_count, output ready);
endinterface

>>> rtl/core/greedy_next_hop_table.sv
// ----------------------------------------------------------------------------
// greedy_next_hop_table
// Neighbor table in one synchronous memory with a greedy next-hop scan.
// ----------------------------------------------------------------------------
// One item at a time. The scan reads one table entry per cycle from the single
// read port of the neighbor memory, followed by a squaring stage, a compare
// stage and the output register. An announcement scans the table for its id
// and, if the id is new and the table has room, appends it at the end; a query
// starts from the own node's distance and keeps the closest neighbor, replacing
// the best so far only on a strictly smaller distance. The next item is taken
// once the result is in the output register, even while that result has not
// yet been taken. No clearing pass is needed after reset. Configuration writes
// are taken at any time.
module greedy_next_hop_table import gnh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	gnh_in_if.sink               item,
	gnh_out_if.source            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	gnh_state_t state_q;

	logic [ID_W-1:0]    own_id_q;
	logic [COORD_W-1:0] own_x_q;
	logic [COORD_W-1:0] own_y_q;

	logic               mode_q;
	logic [ID_W-1:0]    node_id_q;
	logic [COORD_W-1:0] pos_x_q;
	logic [COORD_W-1:0] pos_y_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] issue_q;

	gnh_entry_t mem [NEIGHBORS];
	gnh_entry_t rd_data_s1;
	logic       rd_vld_s1;
	logic       own_s1;

	gnh_entry_t entry_s1;
	logic [COORD_W-1:0] dx, dy;

	gnh_entry_t       entry_s2;
	logic             vld_s2;
	logic             own_s2;
	logic [SQ_W-1:0]  sqx_s2;
	logic [SQ_W-1:0]  sqy_s2;
	logic [DIST_W-1:0] sum_s2;

	logic [DIST_W-1:0] best_q;
	gnh_entry_t        best_entry_q;
	logic              found_q;
	logic              present_q;

	logic in_acc;
	logic out_free;
	logic issue;
	logic mem_we;
	logic [CNT_W-1:0] count_next;

	assign in_acc = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign out_free = !result.valid || result.ready;
	assign issue = (state_q == ST_SCAN) && (issue_q < count_q);
	assign mem_we = (state_q == ST_FINISH) && out_free && (mode_q == MODE_UPDATE)
		&& !present_q && (count_q < CNT_W'(NEIGHBORS));
	assign count_next = mem_we ? count_q + CNT_W'(1) : count_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
			own_x_q  <= '0;
			own_y_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OWN_ID: own_id_q <= cfg_data;
				REG_OWN_X:  own_x_q  <= cfg_data;
				REG_OWN_Y:  own_y_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// neighbor memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[IDX_W-1:0]] <= '{id: node_id_q, x: pos_x_q, y: pos_y_q};
		end
		rd_data_s1 <= mem[issue_q[IDX_W-1:0]];
	end

	// item latch
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q    <= item.mode;
			node_id_q <= item.node_id;
			pos_x_q   <= item.pos_x;
			pos_y_q   <= item.pos_y;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			issue_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					issue_q <= '0;
					if (in_acc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						issue_q <= issue_q + CNT_W'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (out_free) begin
						count_q <= count_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read stage valid; the own node enters ahead of the table for a query
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			own_s1    <= 1'b0;
			vld_s2    <= 1'b0;
		end else begin
			rd_vld_s1 <= issue || (in_acc && item.mode == MODE_QUERY);
			own_s1    <= in_acc && item.mode == MODE_QUERY;
			vld_s2    <= rd_vld_s1;
		end
	end

	assign entry_s1 = own_s1 ? gnh_entry_t'{id: own_id_q, x: own_x_q, y: own_y_q}
		: rd_data_s1;
	assign dx = (entry_s1.x > pos_x_q) ? entry_s1.x - pos_x_q : pos_x_q - entry_s1.x;
	assign dy = (entry_s1.y > pos_y_q) ? entry_s1.y - pos_y_q : pos_y_q - entry_s1.y;

	// squaring stage
	always_ff @(posedge clk) begin
		entry_s2 <= entry_s1;
		own_s2   <= own_s1;
		sqx_s2   <= dx * dx;
		sqy_s2   <= dy * dy;
	end

	assign sum_s2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	// compare stage
	always_ff @(posedge clk) begin
		if (in_acc) begin
			present_q <= 1'b0;
			found_q   <= 1'b0;
		end else if (vld_s2) begin
			if (mode_q == MODE_QUERY) begin
				if (own_s2) begin
					best_q       <= sum_s2;
					best_entry_q <= entry_s2;
				end else if (sum_s2 < best_q) begin
					best_q       <= sum_s2;
					best_entry_q <= entry_s2;
					found_q      <= 1'b1;
				end
			end else if (entry_s2.id == node_id_q) begin
				present_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			result.neighbor_count <= NCOUNT_W'(count_next);
			if (mode_q == MODE_QUERY) begin
				result.next_id    <= best_entry_q.id;
				result.next_x     <= best_entry_q.x;
				result.next_y     <= best_entry_q.y;
				result.stuck      <= !found_q;
				result.added      <= 1'b0;
				result.table_full <= 1'b0;
			end else begin
				result.next_id    <= '0;
				result.next_x     <= '0;
				result.next_y     <= '0;
				result.stuck      <= 1'b0;
				result.added      <= mem_we;
				result.table_full <= !present_q && !mem_we;
			end
		end
	end

endmodule

>>> bench/greedy_next_hop_table_tb.sv
// ----------------------------------------------------------------------------
// greedy_next_hop_table_tb
// Self-checking bench for the greedy next-hop table. A short directed table
// covers the empty table, repeated ids, ties and coordinate extremes. Random
// phases follow, each under its own node setting, with announcements,
// repeated ids and queries aimed near stored neighbors or the own node.
// Every result beat is checked field by field against an internal model of
// the neighbor table, or against the written result of a directed row that has one.
// ----------------------------------------------------------------------------
module greedy_next_hop_table_tb import gnh_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PHASES = 6;
	localparam int unsigned ITEMS_PER_PHASE = 172;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES = 48;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		gnh_mode_t          mode;
		logic [ID_W-1:0]    node_id;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
	} hop_req_t;

	typedef struct packed {
		logic [ID_W-1:0]     next_id;
		logic [COORD_W-1:0]  next_x;
		logic [COORD_W-1:0]  next_y;
		logic                stuck;
		logic                added;
		logic                table_full;
		logic [NCOUNT_W-1:0] neighbor_count;
	} hop_rsp_t;

	typedef struct {
		bit       swap_own;
		hop_req_t req;
		bit       typed;
		hop_rsp_t rsp;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gnh_in_if  hop_req();
	gnh_out_if hop_rsp();

	greedy_next_hop_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (hop_req),
		.result    (hop_rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model of the neighbor table and own node
	gnh_entry_t nbr_table [NEIGHBORS];
	int unsigned nbr_count;
	logic [ID_W-1:0] own_id_m;
	logic [COORD_W-1:0] own_x_m;
	logic [COORD_W-1:0] own_y_m;

	hop_rsp_t pending_hops [$];
	int unsigned mismatch_count;
	int unsigned quiet_cycles;
	bit steady_flow;

	function automatic logic [DIST_W-1:0] span_sq(logic [COORD_W-1:0] ax,
			logic [COORD_W-1:0] ay, logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by);
		logic [COORD_W-1:0] ux;
		logic [COORD_W-1:0] uy;
		logic [DIST_W-1:0] dx;
		logic [DIST_W-1:0] dy;
		ux = (ax > bx) ? ax - bx : bx - ax;
		uy = (ay > by) ? ay - by : by - ay;
		dx = {{(DIST_W-COORD_W){1'b0}}, ux};
		dy = {{(DIST_W-COORD_W){1'b0}}, uy};
		return dx * dx + dy * dy;
	endfunction

	// applies one beat to the table model and returns the result it causes
	function automatic hop_rsp_t choose_next_hop(hop_req_t r);
		hop_rsp_t res;
		logic [DIST_W-1:0] best;
		logic [DIST_W-1:0] d;
		bit known;
		res = '0;
		if (r.mode == MODE_UPDATE) begin
			known = 1'b0;
			for (int i = 0; i < nbr_count; i++)
				if (nbr_table[i].id == r.node_id) known = 1'b1;
			if (!known) begin
				if (nbr_count < NEIGHBORS) begin
					nbr_table[nbr_count] = '{id: r.node_id, x: r.pos_x, y: r.pos_y};
					nbr_count++;
					res.added = 1'b1;
				end else begin
					res.table_full = 1'b1;
				end
			end
		end else begin
			best = span_sq(own_x_m, own_y_m, r.pos_x, r.pos_y);
			res.next_id = own_id_m;
			res.next_x = own_x_m;
			res.next_y = own_y_m;
			res.stuck = 1'b1;
			for (int i = 0; i < nbr_count; i++) begin
				d = span_sq(nbr_table[i].x, nbr_table[i].y, r.pos_x, r.pos_y);
				// strictly closer only, so ties keep the earlier candidate
				if (d < best) begin
					best = d;
					res.next_id = nbr_table[i].id;
					res.next_x = nbr_table[i].x;
					res.next_y = nbr_table[i].y;
					res.stuck = 1'b0;
				end
			end
		end
		res.neighbor_count = NCOUNT_W'(nbr_count);
		return res;
	endfunction

	function automatic hop_req_t upd(logic [15:0] id, logic [15:0] x, logic [15:0] y);
		return '{mode: MODE_UPDATE, node_id: id, pos_x: x, pos_y: y};
	endfunction

	function automatic hop_req_t qry(logic [15:0] id, logic [15:0] x, logic [15:0] y);
		return '{mode: MODE_QUERY, node_id: id, pos_x: x, pos_y: y};
	endfunction

	function automatic hop_rsp_t hop_result(logic [15:0] id, logic [15:0] x,
			logic [15:0] y, logic stuck, logic added, logic full, logic [5:0] cnt);
		return '{next_id: id, next_x: x, next_y: y, stuck: stuck, added: added,
			table_full: full, neighbor_count: cnt};
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned p;
		if (steady_flow) return 0;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 60);
	endfunction

	function automatic logic [15:0] jitter(logic [15:0] v);
		return v + 16'($urandom_range(0, 6)) - 16'd3;
	endfunction

	function automatic hop_req_t random_item();
		hop_req_t r;
		int unsigned p;
		int unsigned k;
		r.node_id = 16'($urandom);
		r.pos_x = 16'($urandom);
		r.pos_y = 16'($urandom);
		p = $urandom_range(0, 99);
		if (p < 30) begin
			r.mode = MODE_UPDATE;
			// announce a stored id again now and then
			if (nbr_count > 0 && $urandom_range(0, 3) == 0)
				r.node_id = nbr_table[$urandom_range(0, nbr_count - 1)].id;
		end else begin
			r.mode = MODE_QUERY;
			if (p < 45) begin
				r.pos_x = jitter(own_x_m);
				r.pos_y = jitter(own_y_m);
			end else if (p < 70 && nbr_count > 0) begin
				k = $urandom_range(0, nbr_count - 1);
				r.pos_x = jitter(nbr_table[k].x);
				r.pos_y = jitter(nbr_table[k].y);
			end
		end
		return r;
	endfunction

	task automatic send_item(hop_req_t r, bit typed, hop_rsp_t want);
		int unsigned gap;
		hop_rsp_t predicted;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			hop_req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		hop_req.valid <= 1'b1;
		hop_req.mode <= r.mode;
		hop_req.node_id <= r.node_id;
		hop_req.pos_x <= r.pos_x;
		hop_req.pos_y <= r.pos_y;
		do @(posedge clk); while (!hop_req.ready);
		predicted = choose_next_hop(r);
		pending_hops = {pending_hops, (typed ? want : predicted)};
	endtask

	task automatic drain_results();
		@(negedge clk);
		hop_req.valid <= 1'b0;
		while (pending_hops.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_own(logic [15:0] id, logic [15:0] x, logic [15:0] y);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_OWN_ID;
		cfg_data <= id;
		@(negedge clk);
		cfg_index <= REG_OWN_X;
		cfg_data <= x;
		@(negedge clk);
		cfg_index <= REG_OWN_Y;
		cfg_data <= y;
		// unused index must leave all registers alone
		@(negedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= 16'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		own_id_m = id;
		own_x_m = x;
		own_y_m = y;
	endtask

	task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin : result_check
		hop_rsp_t want;
		if (arst_n && hop_rsp.valid && hop_rsp.ready) begin
			if (pending_hops.size() == 0) begin
				$display("%0t ns: result beat with nothing expected, got id %0h",
					$time, hop_rsp.next_id);
				mismatch_count++;
			end else begin
				want = pending_hops.pop_front();
				check_field("next_id", want.next_id, hop_rsp.next_id);
				check_field("next_x", want.next_x, hop_rsp.next_x);
				check_field("next_y", want.next_y, hop_rsp.next_y);
				check_field("stuck", 16'(want.stuck), 16'(hop_rsp.stuck));
				check_field("added", 16'(want.added), 16'(hop_rsp.added));
				check_field("table_full", 16'(want.table_full), 16'(hop_rsp.table_full));
				check_field("neighbor_count", 16'(want.neighbor_count),
					16'(hop_rsp.neighbor_count));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((hop_req.valid && hop_req.ready) || (hop_rsp.valid && hop_rsp.ready)) begin
			quiet_cycles = 0;
		end else if (arst_n) begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("greedy_next_hop_table verification failed");
				$finish;
			end
		end
	end

	// result side back-pressure: runs of ready, then stalls of random length
	initial begin : sink_pacing
		int unsigned n;
		hop_rsp.ready = 1'b0;
		wait (arst_n);
		forever begin
			n = $urandom_range(1, 30);
			@(negedge clk) hop_rsp.ready <= 1'b1;
			repeat (n - 1) @(negedge clk);
			n = pick_gap();
			if (n > 0) begin
				@(negedge clk) hop_rsp.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	initial begin : stimulus
		plan_row_t opening_plan [$];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_OWN_ID;
		cfg_data = '0;
		hop_req.valid = 1'b0;
		hop_req.mode = MODE_UPDATE;
		hop_req.node_id = '0;
		hop_req.pos_x = '0;
		hop_req.pos_y = '0;
		nbr_count = 0;
		own_id_m = '0;
		own_x_m = '0;
		own_y_m = '0;
		mismatch_count = 0;
		quiet_cycles = 0;
		steady_flow = 1'b0;

		// own node is 0 at (0,0) out of reset
		opening_plan = '{
			'{0, qry(16'h0000, 16'h0000, 16'h0000), 1,
				hop_result(16'h0, 16'h0, 16'h0, 1, 0, 0, 6'd0)},
			'{0, qry(16'h0000, 16'hFFFF, 16'hFFFF), 1,
				hop_result(16'h0, 16'h0, 16'h0, 1, 0, 0, 6'd0)},
			'{0, upd(16'h1234, 16'hFFFF, 16'hFFFF), 1,
				hop_result(16'h0, 16'h0, 16'h0, 0, 1, 0, 6'd1)},
			'{0, upd(16'h1234, 16'h0000, 16'h0000), 1,
				hop_result(16'h0, 16'h0, 16'h0, 0, 0, 0, 6'd1)},
			'{0, qry(16'h0000, 16'hFFFF, 16'hFFFF), 1,
				hop_result(16'h1234, 16'hFFFF, 16'hFFFF, 0, 0, 0, 6'd1)},
			'{0, upd(16'h0000, 16'h0000, 16'h0000), 1,
				hop_result(16'h0, 16'h0, 16'h0, 0, 1, 0, 6'd2)},
			// neighbor sitting on the own node is a tie and loses
			'{0, qry(16'h0000, 16'h0000, 16'h0000), 1,
				hop_result(16'h0, 16'h0, 16'h0, 1, 0, 0, 6'd2)},
			'{0, upd(16'hFFFF, 16'h8000, 16'h8000), 1,
				hop_result(16'h0, 16'h0, 16'h0, 0, 1, 0, 6'd3)},
			'{0, upd(16'h00FF, 16'h8000, 16'h8000), 1,
				hop_result(16'h0, 16'h0, 16'h0, 0, 1, 0, 6'd4)},
			'{0, qry(16'hFFFF, 16'h8000, 16'h8001), 0, '0},
			'{0, qry(16'h5A5A, 16'h7FFF, 16'h8000), 0, '0},
			// own node moved to a far corner
			'{1, qry(16'h0000, 16'hFFFF, 16'h0000), 0, '0},
			'{0, qry(16'h0000, 16'h0000, 16'hFFFF), 0, '0},
			'{0, upd(16'hFFFF, 16'h0001, 16'h0001), 1,
				hop_result(16'h0, 16'h0, 16'h0, 0, 0, 0, 6'd4)},
			'{0, qry(16'h0000, 16'h0001, 16'h0001), 0, '0},
			'{0, upd(16'hABCD, 16'h5555, 16'hAAAA), 1,
				hop_result(16'h0, 16'h0, 16'h0, 0, 1, 0, 6'd5)},
			'{0, qry(16'hFFFF, 16'h5555, 16'hAAAA), 0, '0},
			'{0, qry(16'h0000, 16'hFFFF, 16'hFFFF), 0, '0}
		};

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (opening_plan[i]) begin
			if (opening_plan[i].swap_own) begin
				drain_results();
				program_own(16'hFFFF, 16'hFFFF, 16'h0000);
			end
			send_item(opening_plan[i].req, opening_plan[i].typed, opening_plan[i].rsp);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			case (phase)
				0: program_own(16'hFFFF, 16'h0000, 16'hFFFF);
				1: program_own(16'h0000, 16'hFFFF, 16'hFFFF);
				2: program_own(16'h0000, 16'h0000, 16'h0000);
				default: program_own(16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			steady_flow = (phase == 3);
			repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, '0);
		end
		steady_flow = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("greedy_next_hop_table verification clean");
		end else begin
			$display("greedy_next_hop_table verification failed");
		end
		$finish;
	end

endmodule
